[hw/rtl/ped_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ped_pkg
// Types, character constants and hex helper shared by the percent-escape
// decoder modules.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // results one input item can cause
    localparam int unsigned MAX_RES = 3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } t_out_item;

    typedef struct packed {
        logic                  ok;
        logic [3:0]            val;
    } t_hex;

    // one classified input: up to three result bytes, oldest in slot 0
    typedef struct packed {
        logic [1:0]                cnt;
        logic [MAX_RES-1:0][7:0]   bytes;
        logic                      str_end;
    } t_cmd;

    function automatic t_hex hex_nibble(input logic [7:0] b);
        t_hex       h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (b >= CH_0 && b <= CH_9) begin
            d     = b - CH_0;
            h.ok  = 1'b1;
        end else if (b >= CH_LA && b <= CH_LF) begin
            d     = b - CH_LA + HEX_TEN;
            h.ok  = 1'b1;
        end else if (b >= CH_UA && b <= CH_UF) begin
            d     = b - CH_UA + HEX_TEN;
            h.ok  = 1'b1;
        end
        h.val = d[3:0];
        return h;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/percent_escape_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// percent_escape_decoder
// URL percent-decoding of a byte stream.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle whenever full is low; full rises only when
// the DEPTH-entry command queue between the classifier and the serializer
// holds DEPTH commands. Each byte is classified in the cycle it is taken and
// yields zero to three result bytes, which leave one per cycle on the result
// side while pop is high and the queue is not empty. An input that yields
// k results holds the result side until all k are popped. A '%' plus two hex digits
// becomes one byte; a broken escape is passed on literally and any escape
// still open at in_last is flushed. run_end marks the last result caused by
// one input, string_end the final result of the string.
// ----------------------------------------------------------------------------
module percent_escape_decoder
    import ped_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_in,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_out
);

    logic cmd_valid;
    t_cmd cmd;
    t_cmd head;
    logic q_full;
    logic q_empty;
    logic q_rd;

    assign full = q_full;

    ped_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    ped_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_cmd   (cmd),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    ped_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .i_pop     (pop),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

[hw/rtl/ped_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ped_front
// Accepts raw bytes, tracks the escape phase and turns each transaction that
// yields a result into one command of up to three result bytes.
// ----------------------------------------------------------------------------
module ped_front
    import ped_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_in,
    input  wire logic     i_q_full,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       acc;
    t_hex       hx;
    t_hex       hh;
    logic       brk;
    t_cmd       cmd;

    assign acc = i_push && !i_q_full;
    assign hx  = hex_nibble(i_in.in_byte);
    assign hh  = hex_nibble(r_held);

    // escape broken or no escape pending: byte is handled as ordinary input
    always_comb begin
        case (r_phase)
            PH_PCT:  brk = !hx.ok;
            PH_DIG:  brk = !hx.ok;
            default: brk = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        if (!brk) begin
            if (r_phase == PH_PCT) begin
                n_phase = PH_DIG;
                n_held  = i_in.in_byte;
            end else begin
                n_phase = PH_IDLE;
                n_held  = '0;
            end
        end else begin
            n_held  = '0;
            n_phase = (i_in.in_byte == PCT_CHAR) ? PH_PCT : PH_IDLE;
        end
        if (i_in.in_last) begin
            n_phase = PH_IDLE;
            n_held  = '0;
        end
    end

    // outputs: bytes are appended in order
    always_comb begin
        cmd         = '0;
        cmd.str_end = i_in.in_last;
        if (brk) begin
            if (r_phase == PH_PCT || r_phase == PH_DIG) begin
                cmd.bytes[cmd.cnt] = PCT_CHAR;
                cmd.cnt            = cmd.cnt + 2'd1;
            end
            if (r_phase == PH_DIG) begin
                cmd.bytes[cmd.cnt] = r_held;
                cmd.cnt            = cmd.cnt + 2'd1;
            end
            if (i_in.in_byte != PCT_CHAR) begin
                cmd.bytes[cmd.cnt] = i_in.in_byte;
                cmd.cnt            = cmd.cnt + 2'd1;
            end
        end else if (r_phase == PH_DIG) begin
            cmd.bytes[cmd.cnt] = {hh.val, hx.val};
            cmd.cnt            = cmd.cnt + 2'd1;
        end
        // end of string flushes whatever escape is still open
        if (i_in.in_last) begin
            if (brk ? (i_in.in_byte == PCT_CHAR) : (r_phase == PH_PCT)) begin
                cmd.bytes[cmd.cnt] = PCT_CHAR;
                cmd.cnt            = cmd.cnt + 2'd1;
            end
            if (!brk && r_phase == PH_PCT) begin
                cmd.bytes[cmd.cnt] = i_in.in_byte;
                cmd.cnt            = cmd.cnt + 2'd1;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = acc && (cmd.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // string end always closes the escape
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.in_last) |=> (r_phase == PH_IDLE))
        else $error("escape still open after end of string");

    // a held digit exists only while one is pending
    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DIG) |-> (r_held == 8'd0))
        else $error("stale held digit");

    // end of string never drops out without a result
    a_last_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.in_last) |-> o_cmd_valid)
        else $error("end of string produced no result");

endmodule
`default_nettype wire

[hw/rtl/ped_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ped_queue
// Short command queue between the classifier and the result serializer.
// ----------------------------------------------------------------------------
module ped_queue
    import ped_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_cmd i_cmd,
    input  wire logic i_rd,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_ok, rd_ok;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (wr_ok) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
        end
        if (rd_ok) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
        end
        case ({wr_ok, rd_ok})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("command written into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count out of range");

endmodule
`default_nettype wire

[hw/rtl/ped_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ped_back
// Walks the head command byte by byte and presents each as a result item,
// marking the end of the run and of the string.
// ----------------------------------------------------------------------------
module ped_back
    import ped_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_cmd i_head,
    input  wire logic i_pop,
    output logic      o_q_rd,
    output logic      o_empty,
    output t_out_item o_out
);

    logic [1:0] r_idx, n_idx;
    logic       at_last;
    logic       take;

    assign at_last = (r_idx == (i_head.cnt - 2'd1));
    assign take    = i_pop && !i_q_empty;
    assign o_q_rd  = take && at_last;
    assign o_empty = i_q_empty;

    assign o_out.out_byte   = i_head.bytes[r_idx];
    assign o_out.run_end    = at_last;
    assign o_out.string_end = at_last && i_head.str_end;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // the byte index stays inside the head command
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (r_idx < i_head.cnt))
        else $error("result index past end of command");

endmodule
`default_nettype wire
